[src/bfaf_pkg.sv]
// Shared types and constants for the bounded flow admission filter.
// No dependencies.
package bfaf_pkg;

    localparam int MAX_FLOWS   = 64;
    localparam int CNT_W       = $clog2(MAX_FLOWS + 1);
    localparam int LIMIT_W     = 7;
    localparam int HELD_W      = 7;
    localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int GRP_SIZE    = 8;
    localparam int NUM_GRPS    = (MAX_FLOWS + GRP_SIZE - 1) / GRP_SIZE;
    localparam int MIN_HDR     = 20;
    localparam int HDR_SUM_W   = 7;
    localparam logic [7:0] PROTO_TCP = 8'd6;

    typedef enum logic [2:0] {
        V_KNOWN   = 3'd0,
        V_NEW     = 3'd1,
        V_FULL    = 3'd2,
        V_BAD_IP  = 3'd3,
        V_NOT_TCP = 3'd4,
        V_BAD_TCP = 3'd5,
        V_EMPTY   = 3'd6
    } verdict_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_RED,
        ST_DEC
    } state_t;

    typedef struct packed {
        logic [3:0]  ip_header_words;
        logic [7:0]  protocol;
        logic [3:0]  tcp_header_words;
        logic [15:0] ip_total_length;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } in_item_t;

    typedef struct packed {
        logic        keep;
        logic [2:0]  verdict;
        logic [6:0]  flows_held;
    } out_item_t;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } flow_key_t;

endpackage

[src/bfaf_cell.sv]
// One flow table cell: holds one tuple, matches it both ways against the query,
// and passes its tuple to the next cell on insert. Depends on bfaf_pkg.
module bfaf_cell
    import bfaf_pkg::*;
(
    input  logic      clk,
    input  logic      shift_en,
    input  flow_key_t shift_in,
    input  flow_key_t query,
    input  logic      entry_valid,
    output flow_key_t entry_out,
    output logic      hit
);

    flow_key_t entry_reg;
    logic      hit_reg;
    flow_key_t swapped;
    logic      hit_next;

    always_comb
    begin
        swapped.src_ip   = query.dst_ip;
        swapped.dst_ip   = query.src_ip;
        swapped.src_port = query.dst_port;
        swapped.dst_port = query.src_port;
        hit_next = entry_valid && ((entry_reg == query) || (entry_reg == swapped));
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            entry_reg <= shift_in;
        end
        hit_reg <= hit_next;
    end

    assign entry_out = entry_reg;
    assign hit       = hit_reg;

endmodule

[src/bfaf_hit_reduce.sv]
// Registered OR tree over the cell hit flags: group ORs registered, final OR combinational.
// Depends on bfaf_pkg.
module bfaf_hit_reduce
    import bfaf_pkg::*;
(
    input  logic                 clk,
    input  logic [MAX_FLOWS-1:0] hits,
    output logic                 any_hit
);

    logic [NUM_GRPS-1:0] grp_reg;
    logic [NUM_GRPS-1:0] grp_next;

    always_comb
    begin
        grp_next = '0;
        for (int g = 0; g < NUM_GRPS; g++)
        begin
            for (int j = 0; j < GRP_SIZE; j++)
            begin
                if (g * GRP_SIZE + j < MAX_FLOWS)
                begin
                    grp_next[g] = grp_next[g] | hits[g * GRP_SIZE + j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg <= grp_next;
    end

    assign any_hit = |grp_reg;

endmodule

[src/bounded_flow_admission_filter_core.sv]
// Flow: item registered in IDLE, cell compare registered in CMP, two-level hit
// OR tree groups registered in RED, result registered in DEC once the output is
// free. One item in flight; a new item is taken only back in IDLE.
// Reset (rst_n, async, active low) empties the flow table count, clears the
// limit to 0 and drops any item in flight. No clearing pass is needed.
// Depends on bfaf_pkg, bfaf_cell, bfaf_hit_reduce.
module bounded_flow_admission_filter_core
    import bfaf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_item,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data
);

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   flow_count_reg;
    logic [CNT_W-1:0]   flow_count_next;
    logic [LIMIT_W-1:0] flow_limit_reg;
    in_item_t           item_reg;
    logic               out_valid_reg;
    out_item_t          out_item_reg;
    out_item_t          out_item_next;

    flow_key_t          query;
    flow_key_t          cell_out [MAX_FLOWS];
    logic [MAX_FLOWS-1:0] hits;
    logic [MAX_FLOWS-1:0] entry_valid;
    logic               any_hit;
    logic               out_free;
    logic               dec_fire;
    logic               insert;
    logic               room;
    logic [HDR_SUM_W-1:0] hdr_bytes;
    verdict_t           verdict;

    assign query.src_ip   = item_reg.src_ip;
    assign query.dst_ip   = item_reg.dst_ip;
    assign query.src_port = item_reg.src_port;
    assign query.dst_port = item_reg.dst_port;

    genvar i;
    generate
        for (i = 0; i < MAX_FLOWS; i++)
        begin : g_cell
            assign entry_valid[i] = CNT_W'(i) < flow_count_reg;
            bfaf_cell u_cell (
                .clk         (clk),
                .shift_en    (insert),
                .shift_in    ((i == 0) ? query : cell_out[(i == 0) ? 0 : i - 1]),
                .query       (query),
                .entry_valid (entry_valid[i]),
                .entry_out   (cell_out[i]),
                .hit         (hits[i])
            );
        end
    endgenerate

    bfaf_hit_reduce u_reduce (
        .clk     (clk),
        .hits    (hits),
        .any_hit (any_hit)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign room     = (CMP_W'(flow_count_reg) < CMP_W'(flow_limit_reg))
                   && (flow_count_reg < CNT_W'(MAX_FLOWS));
    assign hdr_bytes = HDR_SUM_W'({item_reg.ip_header_words, 2'b00})
                     + HDR_SUM_W'({item_reg.tcp_header_words, 2'b00});

    always_comb
    begin
        if ({item_reg.ip_header_words, 2'b00} < 6'(MIN_HDR))
        begin
            verdict = V_BAD_IP;
        end
        else if (item_reg.protocol != PROTO_TCP)
        begin
            verdict = V_NOT_TCP;
        end
        else if ({item_reg.tcp_header_words, 2'b00} < 6'(MIN_HDR))
        begin
            verdict = V_BAD_TCP;
        end
        else if (item_reg.ip_total_length == 16'(hdr_bytes))
        begin
            verdict = V_EMPTY;
        end
        else if (any_hit)
        begin
            verdict = V_KNOWN;
        end
        else if (room)
        begin
            verdict = V_NEW;
        end
        else
        begin
            verdict = V_FULL;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:  state_next = ST_RED;
            ST_RED:  state_next = ST_DEC;
            ST_DEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        dec_fire = 1'b0;
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_DEC:  dec_fire = out_free;
            default:
            begin
                in_ready = 1'b0;
                dec_fire = 1'b0;
            end
        endcase
    end

    assign insert = dec_fire && (verdict == V_NEW);

    always_comb
    begin
        flow_count_next = insert ? flow_count_reg + CNT_W'(1) : flow_count_reg;
        out_item_next.keep       = (verdict == V_KNOWN) || (verdict == V_NEW);
        out_item_next.verdict    = verdict;
        out_item_next.flows_held = HELD_W'(flow_count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            flow_count_reg <= '0;
            flow_limit_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            flow_count_reg <= flow_count_next;
            if (cfg_wr_en)
            begin
                flow_limit_reg <= cfg_wr_data;
            end
            if (dec_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
        if (dec_fire)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        flow_count_reg <= CNT_W'(MAX_FLOWS))
        else $error("flow count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (flow_count_reg != $past(flow_count_reg)) |->
            (flow_count_reg == $past(flow_count_reg) + CNT_W'(1)))
        else $error("flow count changed by other than one");

    a_held_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_item_reg.flows_held == HELD_W'(flow_count_reg)))
        else $error("reported flows differ from table count");

    a_keep_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_item_reg.keep ==
            ((out_item_reg.verdict == V_KNOWN) || (out_item_reg.verdict == V_NEW))))
        else $error("keep disagrees with verdict");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("item accepted while lookup in progress");

endmodule

[test/bounded_flow_admission_filter_core_test.sv]
`timescale 1ns / 1ps
// Testbench for bounded_flow_admission_filter_core: directed table, then random packet
// bursts checked against an in-bench flow table model. Depends on bfaf_pkg and the core.
module bounded_flow_admission_filter_core_test;
    import bfaf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_SLACK = 6;
    localparam int POOL_SIZE   = 96;
    localparam int HOLD_LEN    = 150;

    typedef struct {
        bit         is_cfg;
        logic [6:0] cfg_val;
        in_item_t   pkt;
        bit         typed;
        out_item_t  want;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    in_item_t           in_item;
    logic               out_valid;
    logic               out_ready;
    out_item_t          out_item;
    logic               cfg_wr_en;
    logic [LIMIT_W-1:0] cfg_wr_data;

    flow_key_t held_keys [MAX_FLOWS];
    int        held_n;
    int        limit_now;
    out_item_t verdicts_due [$];
    flow_key_t key_pool [POOL_SIZE];
    dir_row_t  dir_rows [$];

    bit        in_took;
    bit        row_typed;
    out_item_t row_want;
    int        out_seen;
    int        errors;
    int        cycles;
    int        tally [8];

    bounded_flow_admission_filter_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic out_item_t admit_packet(in_item_t p);
        out_item_t r;
        int        ip_b;
        int        tcp_b;
        int        payload;
        int        lim;
        bit        hit;
        flow_key_t e;
        ip_b    = int'(p.ip_header_words) * 4;
        tcp_b   = int'(p.tcp_header_words) * 4;
        payload = int'(p.ip_total_length) - ip_b - tcp_b;
        lim     = (limit_now < MAX_FLOWS) ? limit_now : MAX_FLOWS;
        hit     = 1'b0;
        r.keep  = 1'b0;
        if (ip_b < MIN_HDR)
            r.verdict = V_BAD_IP;
        else if (p.protocol != PROTO_TCP)
            r.verdict = V_NOT_TCP;
        else if (tcp_b < MIN_HDR)
            r.verdict = V_BAD_TCP;
        else if (payload == 0)
            r.verdict = V_EMPTY;
        else
        begin
            for (int i = 0; i < held_n; i++)
            begin
                e = held_keys[i];
                if ((e.src_ip == p.src_ip && e.dst_ip == p.dst_ip &&
                     e.src_port == p.src_port && e.dst_port == p.dst_port) ||
                    (e.src_ip == p.dst_ip && e.dst_ip == p.src_ip &&
                     e.src_port == p.dst_port && e.dst_port == p.src_port))
                    hit = 1'b1;
            end
            if (hit)
            begin
                r.keep    = 1'b1;
                r.verdict = V_KNOWN;
            end
            else if (held_n < lim)
            begin
                held_keys[held_n] = '{p.src_ip, p.dst_ip, p.src_port, p.dst_port};
                held_n++;
                r.keep    = 1'b1;
                r.verdict = V_NEW;
            end
            else
                r.verdict = V_FULL;
        end
        r.flows_held = 7'(held_n);
        return r;
    endfunction

    function automatic in_item_t pkt(int ihw, int proto, int thw, int len,
                                     logic [31:0] sip, logic [31:0] dip,
                                     logic [15:0] sp, logic [15:0] dp);
        in_item_t p;
        p.ip_header_words  = 4'(ihw);
        p.protocol         = 8'(proto);
        p.tcp_header_words = 4'(thw);
        p.ip_total_length  = 16'(len);
        p.src_ip           = sip;
        p.dst_ip           = dip;
        p.src_port         = sp;
        p.dst_port         = dp;
        return p;
    endfunction

    function automatic out_item_t res(bit keep, verdict_t v, int held);
        out_item_t r;
        r.keep       = keep;
        r.verdict    = v;
        r.flows_held = 7'(held);
        return r;
    endfunction

    function automatic in_item_t random_packet();
        in_item_t  p;
        flow_key_t k;
        int        sel;
        int        hdr;
        sel = $urandom_range(0, 99);
        k   = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        if ($urandom_range(0, 9) == 0)
            k = '{$urandom, $urandom, 16'($urandom), 16'($urandom)};
        if ($urandom_range(0, 2) == 0)
            p = pkt(0, 0, 0, 0, k.dst_ip, k.src_ip, k.dst_port, k.src_port);
        else
            p = pkt(0, 0, 0, 0, k.src_ip, k.dst_ip, k.src_port, k.dst_port);
        p.ip_header_words  = 4'($urandom_range(5, 15));
        p.protocol         = PROTO_TCP;
        p.tcp_header_words = 4'($urandom_range(5, 15));
        p.ip_total_length  = 16'($urandom);
        hdr = int'(p.ip_header_words) * 4 + int'(p.tcp_header_words) * 4;
        if (sel < 6)
            p.ip_total_length = 16'(hdr);
        else if (sel < 10)
            p.ip_total_length = 16'($urandom_range(0, hdr - 1));
        else if (sel < 20)
        begin
            p.ip_header_words  = 4'($urandom_range(0, 15));
            p.protocol         = 8'($urandom_range(0, 255));
            p.tcp_header_words = 4'($urandom_range(0, 15));
        end
        return p;
    endfunction

    task automatic add_row(bit is_cfg, int v, in_item_t p, bit typed, out_item_t w);
        dir_row_t row;
        row.is_cfg  = is_cfg;
        row.cfg_val = 7'(v);
        row.pkt     = p;
        row.typed   = typed;
        row.want    = w;
        dir_rows.push_back(row);
    endtask

    task automatic report(string name, int e, int a);
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, e, a);
        errors++;
    endtask

    always @(posedge clk)
    begin : monitor
        out_item_t want;
        if (rst_n)
        begin
            in_took = in_valid && in_ready;
            if (in_took)
            begin
                want = admit_packet(in_item);
                if (row_typed)
                    want = row_want;
                verdicts_due.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                out_seen++;
                tally[out_item.verdict]++;
                if (verdicts_due.size() == 0)
                begin
                    $display("%0t ns: unexpected transfer, expected none, got %h",
                             $time, out_item);
                    errors++;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (out_item.keep !== want.keep)
                        report("keep", want.keep, out_item.keep);
                    if (out_item.verdict !== want.verdict)
                        report("verdict", want.verdict, out_item.verdict);
                    if (out_item.flows_held !== want.flows_held)
                        report("flows_held", want.flows_held, out_item.flows_held);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t ns: timeout", $time);
            $display("** bounded_flow_admission_filter_core: FAILED **");
            $finish;
        end
    end

    // receiver: randomly redrawn ready mode (always, random or sparse), plus two long hold-offs
    initial
    begin : receiver
        int cyc;
        int mode;
        int hold_left;
        int next_hold;
        int hold_at [2];
        cyc       = 0;
        mode      = 0;
        hold_left = 0;
        next_hold = 0;
        hold_at   = '{200, 900};
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 64 == 0)
                mode = $urandom_range(0, 2);
            if (hold_left == 0 && next_hold < 2 && out_seen >= hold_at[next_hold])
            begin
                hold_left = HOLD_LEN;
                next_hold++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (mode == 0)
                out_ready <= 1'b1;
            else if (mode == 1)
                out_ready <= 1'($urandom_range(0, 1));
            else
                out_ready <= (cyc % 4 == 0);
        end
    end

    task automatic offer(in_item_t p, bit typed, out_item_t w);
        in_item   <= p;
        in_valid  <= 1'b1;
        row_typed  = typed;
        row_want   = w;
        do
            @(negedge clk);
        while (!in_took);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_SLACK) @(negedge clk);
    endtask

    task automatic set_flow_limit(logic [6:0] v);
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        limit_now    = int'(v);
    endtask

    task automatic run_random_phase(int n);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && sent < n)
            begin
                offer(random_packet(), 1'b0, '0);
                sent++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    initial
    begin
        int          phase_limits [6];
        logic [31:0] a_ip;
        logic [31:0] b_ip;
        in_item_t    ok;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        row_typed   = 1'b0;
        row_want    = '0;
        in_took     = 1'b0;
        out_seen    = 0;
        errors      = 0;
        cycles      = 0;
        held_n      = 0;
        limit_now   = 0;
        for (int i = 0; i < 8; i++)
            tally[i] = 0;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = '{$urandom, $urandom, 16'($urandom), 16'($urandom)};
        phase_limits = '{10, 40, 5, 127, 64, 0};
        a_ip = 32'h0A00_0001;
        b_ip = 32'h0A00_0002;
        ok   = pkt(5, 6, 5, 100, a_ip, b_ip, 16'd1234, 16'd80);

        // limit is 0 out of reset: header checks in order, then refusal
        add_row(0, 0, ok, 1, res(0, V_FULL, 0));
        add_row(0, 0, pkt(0, 6, 5, 100, a_ip, b_ip, 1, 2), 1, res(0, V_BAD_IP, 0));
        add_row(0, 0, pkt(4, 6, 5, 100, a_ip, b_ip, 1, 2), 1, res(0, V_BAD_IP, 0));
        add_row(0, 0, pkt(15, 0, 5, 100, a_ip, b_ip, 1, 2), 1, res(0, V_NOT_TCP, 0));
        add_row(0, 0, pkt(5, 255, 5, 100, a_ip, b_ip, 1, 2), 1, res(0, V_NOT_TCP, 0));
        add_row(0, 0, pkt(5, 6, 4, 100, a_ip, b_ip, 1, 2), 1, res(0, V_BAD_TCP, 0));
        add_row(0, 0, pkt(0, 17, 0, 0, a_ip, b_ip, 1, 2), 1, res(0, V_BAD_IP, 0));
        add_row(0, 0, pkt(5, 17, 0, 0, a_ip, b_ip, 1, 2), 1, res(0, V_NOT_TCP, 0));
        add_row(0, 0, pkt(5, 6, 5, 40, a_ip, b_ip, 1, 2), 1, res(0, V_EMPTY, 0));
        add_row(0, 0, pkt(15, 6, 15, 120, a_ip, b_ip, 1, 2), 1, res(0, V_EMPTY, 0));
        add_row(1, 3, ok, 0, '0);
        // negative payload goes to lookup; reverse tuple hits
        add_row(0, 0, pkt(5, 6, 5, 0, a_ip, b_ip, 1234, 80), 0, '0);
        add_row(0, 0, pkt(5, 6, 5, 65535, b_ip, a_ip, 80, 1234), 0, '0);
        add_row(0, 0, pkt(15, 6, 15, 65535, '1, '1, '1, '1), 0, '0);
        add_row(0, 0, pkt(5, 6, 5, 41, '0, '0, '0, '0), 0, '0);
        add_row(0, 0, pkt(5, 6, 5, 500, a_ip, '1, 7, 9), 1, res(0, V_FULL, 3));
        add_row(0, 0, pkt(6, 6, 7, 1000, '1, '1, '1, '1), 0, '0);
        // limit lowered below count
        add_row(1, 1, ok, 0, '0);
        add_row(0, 0, ok, 0, '0);
        add_row(0, 0, pkt(5, 6, 5, 500, b_ip, b_ip, 5, 5), 1, res(0, V_FULL, 3));
        // limit above capacity
        add_row(1, 127, ok, 0, '0);
        add_row(0, 0, pkt(5, 6, 5, 500, b_ip, b_ip, 5, 5), 0, '0);
        add_row(0, 0, pkt(3, 6, 5, 500, b_ip, b_ip, 5, 5), 1, res(0, V_BAD_IP, 4));

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                drain();
                set_flow_limit(dir_rows[i].cfg_val);
            end
            else
                offer(dir_rows[i].pkt, dir_rows[i].typed, dir_rows[i].want);
        end

        foreach (phase_limits[i])
        begin
            drain();
            set_flow_limit(7'(phase_limits[i]));
            run_random_phase(225);
        end
        drain();

        $display("%0d transfers checked across limits 0 to 127, %0d flows held at end",
                 out_seen, held_n);
        $display("known %0d, new %0d, full %0d, bad ip %0d, not tcp %0d, bad tcp %0d, empty %0d",
                 tally[V_KNOWN], tally[V_NEW], tally[V_FULL], tally[V_BAD_IP],
                 tally[V_NOT_TCP], tally[V_BAD_TCP], tally[V_EMPTY]);
        if (errors == 0 && verdicts_due.size() == 0)
            $display("** bounded_flow_admission_filter_core: PASSED **");
        else
            $display("** bounded_flow_admission_filter_core: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
src/bfaf_pkg.sv
src/bfaf_cell.sv
src/bfaf_hit_reduce.sv
src/bounded_flow_admission_filter_core.sv
test/bounded_flow_admission_filter_core_test.sv
